[design/fppft_pkg.sv]
// Shared types, constants and helper functions for the PI loop frequency tracker.
// Holds the quarter-wave sine table built at elaboration time.
// No dependencies; every other design file refers to this package by scoped names.
package fppft_pkg;

    // Field widths.
    localparam int DATA_W  = 32;
    localparam int PHASE_W = 30;
    localparam int PROD_W  = 65;
    localparam int OPA_W   = 33;

    // Sine table geometry: a full period of TableDepth entries, stored as a quarter wave.
    localparam int TableDepth = 1024;
    localparam int IDX_W      = $clog2(TableDepth);
    localparam int Qtr        = TableDepth / 4;
    localparam int QIDX_W     = $clog2(Qtr) + 1;
    localparam int SINE_W     = 31;

    // Angle in radians between neighbouring quarter-wave entries.
    localparam real QTR_STEP  = 3.14159265358979323846 / 2.0 / real'(Qtr);

    // Loop constants.
    localparam logic [DATA_W-1:0] NOMINAL_FREQ = 32'(50) << 25;
    // Phase increment is freq * 32 / 40000, that is freq / 1250.
    localparam int FsDiv       = 40000 / 32;
    localparam int RECIP_SHIFT = 41;
    localparam logic [DATA_W-1:0] RECIP_M = 32'((64'd1 << RECIP_SHIFT) / 64'(FsDiv));
    localparam int QUO_W       = 21;

    // One request to the shared multiplier.
    typedef struct packed {
        logic                     en;
        logic signed [OPA_W-1:0]  a;
        logic signed [DATA_W-1:0] b;
    } t_mul_req;

    typedef logic [SINE_W-1:0] t_qsine_tbl [0:Qtr];

    // round(sin(pi/2 * k / Qtr) * 2^30) for k = 0 .. Qtr.
    function automatic t_qsine_tbl f_build_qsine();
        t_qsine_tbl tbl;
        real        ang;
        real        v;
        for (int k = 0; k <= Qtr; k++) begin
            ang    = QTR_STEP * real'(k);
            v      = $sin(ang) * 1073741824.0;
            tbl[k] = SINE_W'($rtoi(v + 0.5));
        end
        return tbl;
    endfunction

    localparam t_qsine_tbl QSINE_TBL = f_build_qsine();

    // Saturating 32-bit signed add.
    function automatic logic [DATA_W-1:0] f_sat_add(input logic [DATA_W-1:0] a,
                                                    input logic [DATA_W-1:0] b);
        logic [DATA_W:0] sum;
        sum = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (sum[DATA_W] != sum[DATA_W-1]) begin
            return sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return sum[DATA_W-1:0];
    endfunction

endpackage

[design/fppft_sine_lut.sv]
// Sine lookup for a 10-bit phase index, folded onto the quarter-wave table.
// Depends on fppft_pkg for the table and its geometry.
module fppft_sine_lut (
    input  logic [fppft_pkg::IDX_W-1:0]  i_idx,
    output logic [fppft_pkg::DATA_W-1:0] o_sine
);

    logic [1:0]                        w_quad;
    logic [fppft_pkg::IDX_W-3:0]       w_ofs;
    logic [fppft_pkg::QIDX_W-1:0]      w_qidx;
    logic [fppft_pkg::SINE_W-1:0]      w_mag;

    // Second and fourth quarters run the table backwards; the lower half is negated.
    always_comb begin
        w_quad = i_idx[fppft_pkg::IDX_W-1:fppft_pkg::IDX_W-2];
        w_ofs  = i_idx[fppft_pkg::IDX_W-3:0];
        if (w_quad[0]) begin
            w_qidx = fppft_pkg::QIDX_W'(fppft_pkg::Qtr) - {1'b0, w_ofs};
        end else begin
            w_qidx = {1'b0, w_ofs};
        end
        w_mag  = fppft_pkg::QSINE_TBL[w_qidx];
        if (w_quad[1]) begin
            o_sine = 32'(0) - {1'b0, w_mag};
        end else begin
            o_sine = {1'b0, w_mag};
        end
    end

endmodule

[design/fppft_mul.sv]
// Shared signed 33 x 32 multiplier with a registered product and a Q2.30 view of it.
// Depends on fppft_pkg for widths and the request type.
module fppft_mul (
    input  logic                                 i_clk,
    input  fppft_pkg::t_mul_req                  i_req,
    output logic signed [fppft_pkg::PROD_W-1:0]  o_prod,
    output logic [fppft_pkg::DATA_W-1:0]         o_q30
);

    logic signed [fppft_pkg::PROD_W-1:0] r_prod;
    logic signed [fppft_pkg::PROD_W-1:0] n_prod;
    logic [fppft_pkg::PROD_W-31:0]       w_shift;

    assign n_prod = i_req.a * i_req.b;

    // Product register; only loaded when a step asks for the multiplier.
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= n_prod;
        end
    end

    // Floor shift by 30, then saturate to 32 bits signed.
    always_comb begin
        w_shift = r_prod[fppft_pkg::PROD_W-1:30];
        if (w_shift[fppft_pkg::PROD_W-31:fppft_pkg::DATA_W-1] == '0 ||
            w_shift[fppft_pkg::PROD_W-31:fppft_pkg::DATA_W-1] == '1) begin
            o_q30 = w_shift[fppft_pkg::DATA_W-1:0];
        end else if (w_shift[fppft_pkg::PROD_W-31]) begin
            o_q30 = {1'b1, {(fppft_pkg::DATA_W-1){1'b0}}};
        end else begin
            o_q30 = {1'b0, {(fppft_pkg::DATA_W-1){1'b1}}};
        end
    end

    assign o_prod = r_prod;

endmodule

[design/fixed_point_pi_pll_frequency_tracker_top.sv]
// Top level of the PI loop frequency tracker: sequencer, loop state and stream ports.
// Depends on fppft_pkg, fppft_sine_lut and fppft_mul.
//
// Usage: one signed Q22 grid sample arrives per request on the slave stream
// (i_s_axis_*). For each sample the block returns one request on the master
// stream (o_m_axis_*) carrying the frequency estimate, the advanced NCO phase
// and the sine and cosine that were applied to the sample.
// Gains are written through i_cfg_we / i_cfg_addr / i_cfg_data: index 0 is the
// proportional gain, index 1 the integral gain, both signed Q2.30.
// Sequencing: a new sample is taken only once the sequencer is back in idle,
// so the block does not start a sample before the last one has passed its
// final step. That is set by the single shared multiplier, used five times
// per sample (sample times sine, two gain products, the reciprocal divide by
// 1250 and its back-multiply).
// Reset clears the phase, the integrator, both gains and the output request.
// If the receiver stalls, the result waits in the output register; the next
// sample may still be accepted and is worked up to its final step, where it
// waits until the earlier result has been taken.
module fixed_point_pi_pll_frequency_tracker_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Sample stream in. tdata: sample_in[31:0]
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [31:0]  i_s_axis_tdata,
    // Result stream out. tdata: freq_estimate[31:0], phase_next[61:32],
    // sine_used[93:62], cosine_used[125:94], zero padding[127:126]
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata,
    // Gain register writes.
    input  logic         i_cfg_we,
    input  logic         i_cfg_addr,
    input  logic [31:0]  i_cfg_data
);

    localparam int DW = fppft_pkg::DATA_W;
    localparam int PW = fppft_pkg::PHASE_W;
    localparam int QW = fppft_pkg::QUO_W;

    // Register indexes.
    localparam logic REG_PROP_GAIN     = 1'b0;
    localparam logic REG_INTEGRAL_GAIN = 1'b1;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SIN  = 4'd1;
    localparam logic [3:0] ST_COS  = 4'd2;
    localparam logic [3:0] ST_ERR  = 4'd3;
    localparam logic [3:0] ST_KP   = 4'd4;
    localparam logic [3:0] ST_KI   = 4'd5;
    localparam logic [3:0] ST_INT  = 4'd6;
    localparam logic [3:0] ST_FRQ  = 4'd7;
    localparam logic [3:0] ST_RCP  = 4'd8;
    localparam logic [3:0] ST_QUO  = 4'd9;
    localparam logic [3:0] ST_BACK = 4'd10;
    localparam logic [3:0] ST_FIX  = 4'd11;

    logic [3:0]    r_state,  n_state;
    logic [DW-1:0] r_kp,     r_ki;
    logic [PW-1:0] r_phase,  n_phase;
    logic [DW-1:0] r_integ,  n_integ;
    logic [DW-1:0] r_x,      n_x;
    logic [DW-1:0] r_sin,    n_sin;
    logic [DW-1:0] r_cos,    n_cos;
    logic [DW-1:0] r_err,    n_err;
    logic [DW-1:0] r_pterm,  n_pterm;
    logic [DW-1:0] r_freq,   n_freq;
    logic [QW-1:0] r_quo,    n_quo;
    logic          r_out_valid, n_out_valid;
    logic [127:0]  r_out_data,  n_out_data;

    logic [fppft_pkg::IDX_W-1:0]  w_lut_idx;
    logic [DW-1:0]                w_lut_sine;
    fppft_pkg::t_mul_req          w_mul_req;
    logic signed [fppft_pkg::PROD_W-1:0] w_prod;
    logic [DW-1:0]                w_q30;
    logic [DW-1:0]                w_u;
    logic [DW-1:0]                w_mag;
    logic [DW-1:0]                w_rem;
    logic [QW-1:0]                w_quo_fix;
    logic [PW-1:0]                w_inc;
    logic                         w_in_acc;
    logic                         w_out_free;

    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // Magnitude of the frequency; the most negative value maps to 2^31 unsigned.
    assign w_mag = r_freq[DW-1] ? (DW'(0) - r_freq) : r_freq;

    // Sine index comes from the top phase bits; cosine is a quarter turn on.
    assign w_lut_idx = (r_state == ST_COS)
                     ? r_phase[PW-1:PW-fppft_pkg::IDX_W] + fppft_pkg::IDX_W'(fppft_pkg::Qtr)
                     : r_phase[PW-1:PW-fppft_pkg::IDX_W];

    fppft_sine_lut u_lut (
        .i_idx  (w_lut_idx),
        .o_sine (w_lut_sine)
    );

    fppft_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mul_req),
        .o_prod (w_prod),
        .o_q30  (w_q30)
    );

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_req = '0;
        case (r_state)
            ST_COS: begin
                w_mul_req.en = 1'b1;
                w_mul_req.a  = {r_x[DW-1], r_x};
                w_mul_req.b  = r_sin;
            end
            ST_KP: begin
                w_mul_req.en = 1'b1;
                w_mul_req.a  = {r_kp[DW-1], r_kp};
                w_mul_req.b  = r_err;
            end
            ST_KI: begin
                w_mul_req.en = 1'b1;
                w_mul_req.a  = {r_ki[DW-1], r_ki};
                w_mul_req.b  = r_err;
            end
            ST_RCP: begin
                w_mul_req.en = 1'b1;
                w_mul_req.a  = {1'b0, w_mag};
                w_mul_req.b  = fppft_pkg::RECIP_M;
            end
            ST_BACK: begin
                w_mul_req.en = 1'b1;
                w_mul_req.a  = fppft_pkg::OPA_W'(r_quo);
                w_mul_req.b  = DW'(fppft_pkg::FsDiv);
            end
            default: begin
                w_mul_req = '0;
            end
        endcase
    end

    // Division correction: the reciprocal estimate is at most one below the true quotient.
    always_comb begin
        w_rem     = w_mag - w_prod[DW-1:0];
        w_quo_fix = (w_rem >= DW'(fppft_pkg::FsDiv)) ? r_quo + QW'(1) : r_quo;
        w_inc     = r_freq[DW-1] ? (PW'(0) - PW'(w_quo_fix)) : PW'(w_quo_fix);
        w_u       = fppft_pkg::f_sat_add(r_pterm, r_integ);
    end

    // Sequencer and datapath next values.
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_integ     = r_integ;
        n_x         = r_x;
        n_sin       = r_sin;
        n_cos       = r_cos;
        n_err       = r_err;
        n_pterm     = r_pterm;
        n_freq      = r_freq;
        n_quo       = r_quo;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_x     = {i_s_axis_tdata[DW-9:0], 8'h00};
                    n_state = ST_SIN;
                end
            end
            ST_SIN: begin
                n_sin   = w_lut_sine;
                n_state = ST_COS;
            end
            ST_COS: begin
                n_cos   = w_lut_sine;
                n_state = ST_ERR;
            end
            ST_ERR: begin
                // Negation wraps, so a saturated minimum stays the minimum.
                n_err   = DW'(0) - w_q30;
                n_state = ST_KP;
            end
            ST_KP: begin
                n_state = ST_KI;
            end
            ST_KI: begin
                n_pterm = w_q30;
                n_state = ST_INT;
            end
            ST_INT: begin
                n_integ = fppft_pkg::f_sat_add(r_integ, w_q30);
                n_state = ST_FRQ;
            end
            ST_FRQ: begin
                n_freq  = fppft_pkg::NOMINAL_FREQ + {{5{w_u[DW-1]}}, w_u[DW-1:5]};
                n_state = ST_RCP;
            end
            ST_RCP: begin
                n_state = ST_QUO;
            end
            ST_QUO: begin
                n_quo   = w_prod[fppft_pkg::RECIP_SHIFT+QW-1:fppft_pkg::RECIP_SHIFT];
                n_state = ST_BACK;
            end
            ST_BACK: begin
                n_state = ST_FIX;
            end
            ST_FIX: begin
                // Commit the phase only when the output register can take the result.
                if (w_out_free) begin
                    n_phase     = r_phase + w_inc;
                    n_out_valid = 1'b1;
                    n_out_data  = {2'b00, r_cos, r_sin, r_phase + w_inc, r_freq};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and loop state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= '0;
            r_integ     <= '0;
            r_kp        <= '0;
            r_ki        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_integ     <= n_integ;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && i_cfg_addr == REG_PROP_GAIN) begin
                r_kp <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_addr == REG_INTEGRAL_GAIN) begin
                r_ki <= i_cfg_data;
            end
        end
    end

    // Working registers of the current sample.
    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_sin      <= n_sin;
        r_cos      <= n_cos;
        r_err      <= n_err;
        r_pterm    <= n_pterm;
        r_freq     <= n_freq;
        r_quo      <= n_quo;
        r_out_data <= n_out_data;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // A new result only appears as the final step completes.
    a_out_from_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_FIX)
        else $error("result appeared outside the final step");

    // An accepted sample starts the table lookup next cycle.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state == ST_SIN)
        else $error("accepted sample did not start the sequence");

    // The final step waits while an earlier result is still held.
    a_fix_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIX && r_out_valid && !i_m_axis_tready) |=> r_state == ST_FIX)
        else $error("final step overwrote a pending result");

    // A pending result always carries the current loop phase.
    a_phase_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_data[61:32] == r_phase)
        else $error("pending result phase differs from loop phase");

endmodule
